>>> rtl/slid_pkg.sv
package slid_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned OCC_W  = 5;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_DUMP   = 2'd2
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE      = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_PUT,
    S_DEL_SCAN,
    S_DEL_SHIFT,
    S_DUMP,
    S_RESP
  } state_e;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_t;

endpackage

>>> rtl/slid_ram.sv
module slid_ram import slid_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/slid_cmp.sv
module slid_cmp import slid_pkg::*; (
  input  logic [DATA_W-1:0] entry_i,
  input  logic [DATA_W-1:0] key_i,
  output cmp_t              cmp_o
);

  assign cmp_o.lt = $signed(entry_i) < $signed(key_i);
  assign cmp_o.eq = entry_i == key_i;

endmodule

>>> rtl/sorted_list_insert_delete.sv
// Insert: each stored value not less than the key moves up one place, then the key is written.
// Delete: scans up to the match, then moves each value above it down one place; a miss ends the scan early.
// Dump: one result per cycle while the output is not stalled, after a registered table read.
// A refused insert, or a delete or dump on an empty table, goes straight to the response state.
// One item is in work at a time; the one-read one-write table and one comparator set the rate.
// Reset clears the entry count and the control state; table contents are not cleared.
module sorted_list_insert_delete import slid_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [DATA_W-1:0]      s_axis_tdata,  // item_value[31:0]
  input  logic [OP_W-1:0]        s_axis_tuser,  // operation[1:0]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // out_value[31:0], occupancy[36:32], zeros
  output logic [STAT_W-1:0]      m_axis_tuser,  // status[1:0]
  output logic                   m_axis_tlast   // last_flag
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic [DATA_W-1:0] value_q, value_d;
  status_e           resp_q, resp_d;

  logic              out_valid_q;
  logic [DATA_W-1:0] out_value_q;
  status_e           out_status_q;
  logic              out_last_q;
  logic [OCC_W-1:0]  out_occ_q;

  logic              out_load;
  logic [DATA_W-1:0] load_value;
  status_e           load_status;
  logic              load_last;
  logic              can_emit;

  logic              we;
  logic [IW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic              re;
  logic [IW-1:0]     raddr;
  logic [DATA_W-1:0] rdata;
  cmp_t              cmp;

  logic              in_xfer;
  logic [CW-1:0]     idx_ext;
  logic [CW-1:0]     idx_next;

  slid_ram #(
    .DEPTH (CAPACITY),
    .AW    (IW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  slid_cmp u_cmp (
    .entry_i (rdata),
    .key_i   (value_q),
    .cmp_o   (cmp)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign can_emit      = !out_valid_q || m_axis_tready;
  assign idx_ext       = CW'(idx_q);
  assign idx_next      = idx_ext + CW'(1);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    value_d     = value_q;
    resp_d      = resp_q;
    we          = 1'b0;
    waddr       = idx_q;
    wdata       = rdata;
    re          = 1'b0;
    raddr       = '0;
    out_load    = 1'b0;
    load_value  = '0;
    load_status = STAT_DONE;
    load_last   = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          value_d = s_axis_tdata;
          idx_d   = '0;
          unique case (s_axis_tuser)
            OP_INSERT: begin
              if (count_q >= CW'(CAPACITY)) begin
                resp_d  = STAT_FULL;
                state_d = S_RESP;
              end else if (count_q == '0) begin
                state_d = S_INS_PUT;
              end else begin
                idx_d   = IW'(count_q);
                re      = 1'b1;
                raddr   = IW'(count_q - CW'(1));
                state_d = S_INS_CMP;
              end
            end
            OP_DELETE: begin
              if (count_q == '0) begin
                resp_d  = STAT_NOT_FOUND;
                state_d = S_RESP;
              end else begin
                re      = 1'b1;
                state_d = S_DEL_SCAN;
              end
            end
            OP_DUMP: begin
              if (count_q == '0) begin
                resp_d  = STAT_EMPTY;
                state_d = S_RESP;
              end else begin
                re      = 1'b1;
                state_d = S_DUMP;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_INS_CMP: begin
        we    = 1'b1;
        waddr = idx_q;
        if (cmp.lt) begin
          wdata   = value_q;
          count_d = count_q + CW'(1);
          resp_d  = STAT_DONE;
          state_d = S_RESP;
        end else begin
          wdata = rdata;
          idx_d = idx_q - IW'(1);
          if (idx_q == IW'(1)) begin
            state_d = S_INS_PUT;
          end else begin
            re    = 1'b1;
            raddr = idx_q - IW'(2);
          end
        end
      end

      S_INS_PUT: begin
        we      = 1'b1;
        waddr   = idx_q;
        wdata   = value_q;
        count_d = count_q + CW'(1);
        resp_d  = STAT_DONE;
        state_d = S_RESP;
      end

      S_DEL_SCAN: begin
        if (cmp.lt) begin
          if (idx_next == count_q) begin
            resp_d  = STAT_NOT_FOUND;
            state_d = S_RESP;
          end else begin
            re    = 1'b1;
            raddr = IW'(idx_next);
            idx_d = IW'(idx_next);
          end
        end else if (cmp.eq) begin
          if (idx_next == count_q) begin
            count_d = count_q - CW'(1);
            resp_d  = STAT_DONE;
            state_d = S_RESP;
          end else begin
            re      = 1'b1;
            raddr   = IW'(idx_next);
            state_d = S_DEL_SHIFT;
          end
        end else begin
          resp_d  = STAT_NOT_FOUND;
          state_d = S_RESP;
        end
      end

      S_DEL_SHIFT: begin
        we    = 1'b1;
        waddr = idx_q;
        wdata = rdata;
        idx_d = IW'(idx_next);
        if (idx_next + CW'(1) == count_q) begin
          count_d = count_q - CW'(1);
          resp_d  = STAT_DONE;
          state_d = S_RESP;
        end else begin
          re    = 1'b1;
          raddr = IW'(idx_next + CW'(1));
        end
      end

      S_DUMP: begin
        if (can_emit) begin
          out_load    = 1'b1;
          load_value  = rdata;
          load_status = STAT_DONE;
          load_last   = (idx_next == count_q);
          if (idx_next == count_q) begin
            state_d = S_IDLE;
          end else begin
            re    = 1'b1;
            raddr = IW'(idx_next);
            idx_d = IW'(idx_next);
          end
        end
      end

      S_RESP: begin
        if (can_emit) begin
          out_load    = 1'b1;
          load_status = resp_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    value_q <= value_d;
    resp_q  <= resp_d;
    if (out_load) begin
      out_value_q  <= load_value;
      out_status_q <= load_status;
      out_last_q   <= load_last;
      out_occ_q    <= OCC_W'(count_q);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - DATA_W - OCC_W){1'b0}}, out_occ_q, out_value_q};
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

  a_count_bound : assert property (
    @(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(CAPACITY)
  ) else $error("entry count above capacity");

  a_full_refused : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s_axis_tuser == OP_INSERT && count_q == CW'(CAPACITY))
    |=> (count_q == $past(count_q))
  ) else $error("refused insert changed the count");

  a_empty_delete : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s_axis_tuser == OP_DELETE && count_q == '0) |=> (count_q == '0)
  ) else $error("delete on an empty table changed the count");

  a_status_last : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != STAT_DONE) |-> m_axis_tlast
  ) else $error("status transfer not marked last");

endmodule
